[sv/ets_pkg.sv]
package ets_pkg;

    localparam int STAGES = 11;

    typedef enum logic [1:0] {
        REG_BASE_EPOCH = 2'd0,
        REG_SET_TIME   = 2'd1,
        REG_ZONE       = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_index_t;

    localparam logic [15:0] ZONE_RESET    = 16'd19800;

    // floor(x / 1000) = ((x >> 3) * MS_RECIP) >> 36 for 32-bit x
    localparam logic [29:0] MS_RECIP      = 30'd549755814;
    // floor(t / 86400) = ((t >> 7) * DAY_RECIP) >> 35 for 32-bit t
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;

    // day count moved to a 1968-01-01 origin, 2100-02-29 inserted
    localparam logic [15:0] EPOCH_DAY_OFS = 16'd731;
    localparam logic [15:0] SKIP_2100_DAY = 16'd48272;
    localparam logic [16:0] QUAD_RECIP    = 17'd91868;
    localparam logic [10:0] QUAD_DAYS     = 11'd1461;
    localparam logic [11:0] BASE_YEAR     = 12'd1968;

    localparam logic [17:0] MIN_RECIP     = 18'd139811;
    localparam logic [11:0] HOUR_RECIP    = 12'd2185;

    function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
        logic [8:0] base;
        logic [8:0] fix;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        fix = (leap && (idx >= 4'd2)) ? 9'd1 : 9'd0;
        return base + fix;
    endfunction

endpackage

[sv/ets_epoch_sec.sv]
module ets_epoch_sec
    import ets_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [31:0] now_ms,
    input  logic [31:0] set_time_ms,
    input  logic [31:0] base_epoch_seconds,
    input  logic [15:0] zone_offset_seconds,
    output logic [31:0] t_sec
);

    logic [31:0] diff_reg;
    logic [31:0] diff_next;
    logic [58:0] prod_reg;
    logic [58:0] prod_next;
    logic [31:0] t_reg;
    logic [31:0] t_next;

    always_comb
    begin
        diff_next = now_ms - set_time_ms;
        prod_next = 59'(diff_reg[31:3]) * 59'(MS_RECIP);
        t_next    = base_epoch_seconds + {9'd0, prod_reg[58:36]} + {16'd0, zone_offset_seconds};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= diff_next;
            prod_reg <= prod_next;
            t_reg    <= t_next;
        end
    end

    assign t_sec = t_reg;

endmodule

[sv/ets_day_split.sv]
module ets_day_split
    import ets_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [31:0] t_sec,
    output logic [16:0] sec_of_day,
    output logic [15:0] day_adj
);

    logic [50:0] dprod_reg;
    logic [50:0] dprod_next;
    logic [16:0] tlo_a_reg;
    logic [16:0] tlo_a_next;
    logic [15:0] days_reg;
    logic [15:0] days_next;
    logic [16:0] dm_reg;
    logic [16:0] dm_next;
    logic [16:0] tlo_b_reg;
    logic [16:0] tlo_b_next;
    logic [16:0] sod_reg;
    logic [16:0] sod_next;
    logic [15:0] dadj_reg;
    logic [15:0] dadj_next;
    logic [32:0] dm_full;
    logic [15:0] dshift;

    always_comb
    begin
        dprod_next = 51'(t_sec[31:7]) * 51'(DAY_RECIP);
        tlo_a_next = t_sec[16:0];

        days_next  = dprod_reg[50:35];
        dm_full    = 33'(days_next) * 33'(SEC_PER_DAY);
        dm_next    = dm_full[16:0];
        tlo_b_next = tlo_a_reg;

        sod_next   = tlo_b_reg - dm_reg;
        dshift     = days_reg + EPOCH_DAY_OFS;
        dadj_next  = (dshift >= SKIP_2100_DAY) ? dshift + 16'd1 : dshift;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dprod_reg <= dprod_next;
            tlo_a_reg <= tlo_a_next;
            days_reg  <= days_next;
            dm_reg    <= dm_next;
            tlo_b_reg <= tlo_b_next;
            sod_reg   <= sod_next;
            dadj_reg  <= dadj_next;
        end
    end

    assign sec_of_day = sod_reg;
    assign day_adj    = dadj_reg;

endmodule

[sv/ets_tod.sv]
module ets_tod
    import ets_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [16:0] sec_of_day,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour
);

    logic [34:0] mprod_reg;
    logic [34:0] mprod_next;
    logic [16:0] sod_a_reg;
    logic [16:0] sod_a_next;
    logic [10:0] mt_a_reg;
    logic [10:0] mt_a_next;
    logic [16:0] sod_b_reg;
    logic [16:0] sod_b_next;
    logic [22:0] hprod_reg;
    logic [22:0] hprod_next;
    logic [10:0] mt_b_reg;
    logic [10:0] mt_b_next;
    logic [5:0]  sec_a_reg;
    logic [5:0]  sec_a_next;
    logic [4:0]  hour_a_reg;
    logic [4:0]  hour_a_next;
    logic [5:0]  min_a_reg;
    logic [5:0]  min_a_next;
    logic [5:0]  sec_b_reg;
    logic [5:0]  sec_b_next;
    logic [5:0]  sec_o_reg;
    logic [5:0]  min_o_reg;
    logic [4:0]  hour_o_reg;
    logic [16:0] msec;
    logic [16:0] sec_full;
    logic [10:0] hmin;
    logic [10:0] min_full;

    always_comb
    begin
        mprod_next  = 35'(sec_of_day) * 35'(MIN_RECIP);
        sod_a_next  = sec_of_day;

        mt_a_next   = mprod_reg[33:23];
        sod_b_next  = sod_a_reg;

        msec        = 17'(mt_a_reg) * 17'd60;
        sec_full    = sod_b_reg - msec;
        sec_a_next  = sec_full[5:0];
        hprod_next  = 23'(mt_a_reg) * 23'(HOUR_RECIP);
        mt_b_next   = mt_a_reg;

        hour_a_next = hprod_reg[21:17];
        hmin        = 11'(hour_a_next) * 11'd60;
        min_full    = mt_b_reg - hmin;
        min_a_next  = min_full[5:0];
        sec_b_next  = sec_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mprod_reg  <= mprod_next;
            sod_a_reg  <= sod_a_next;
            mt_a_reg   <= mt_a_next;
            sod_b_reg  <= sod_b_next;
            sec_a_reg  <= sec_a_next;
            hprod_reg  <= hprod_next;
            mt_b_reg   <= mt_b_next;
            hour_a_reg <= hour_a_next;
            min_a_reg  <= min_a_next;
            sec_b_reg  <= sec_b_next;
            sec_o_reg  <= sec_b_reg;
            min_o_reg  <= min_a_reg;
            hour_o_reg <= hour_a_reg;
        end
    end

    assign second = sec_o_reg;
    assign minute = min_o_reg;
    assign hour   = hour_o_reg;

endmodule

[sv/ets_date.sv]
module ets_date
    import ets_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [15:0] day_adj,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [11:0] year_number
);

    logic [32:0] qprod_reg;
    logic [32:0] qprod_next;
    logic [15:0] d_a_reg;
    logic [15:0] d_a_next;
    logic [5:0]  quad_a_reg;
    logic [5:0]  quad_a_next;
    logic [15:0] d_b_reg;
    logic [15:0] d_b_next;
    logic [10:0] rem_reg;
    logic [10:0] rem_next;
    logic [5:0]  quad_b_reg;
    logic [5:0]  quad_b_next;
    logic [11:0] year_a_reg;
    logic [11:0] year_a_next;
    logic [8:0]  doy_reg;
    logic [8:0]  doy_next;
    logic        leap_reg;
    logic        leap_next;
    logic [11:0] year_o_reg;
    logic [3:0]  month_o_reg;
    logic [3:0]  month_next;
    logic [4:0]  day_o_reg;
    logic [4:0]  day_next;
    logic [15:0] qdays;
    logic [15:0] rem_full;
    logic [1:0]  y4;
    logic [10:0] doy_full;
    logic [3:0]  midx;
    logic [8:0]  dom;

    always_comb
    begin
        qprod_next  = 33'(day_adj) * 33'(QUAD_RECIP);
        d_a_next    = day_adj;

        quad_a_next = qprod_reg[32:27];
        d_b_next    = d_a_reg;

        qdays       = 16'(quad_a_reg) * 16'(QUAD_DAYS);
        rem_full    = d_b_reg - qdays;
        rem_next    = rem_full[10:0];
        quad_b_next = quad_a_reg;

        if (rem_reg >= 11'd1096)
        begin
            y4       = 2'd3;
            doy_full = rem_reg - 11'd1096;
        end
        else if (rem_reg >= 11'd731)
        begin
            y4       = 2'd2;
            doy_full = rem_reg - 11'd731;
        end
        else if (rem_reg >= 11'd366)
        begin
            y4       = 2'd1;
            doy_full = rem_reg - 11'd366;
        end
        else
        begin
            y4       = 2'd0;
            doy_full = rem_reg;
        end
        doy_next    = doy_full[8:0];
        leap_next   = (y4 == 2'd0);
        year_a_next = BASE_YEAR + 12'({quad_b_reg, 2'b00}) + 12'(y4);

        midx = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy_reg >= month_start(4'(i), leap_reg))
            begin
                midx = 4'(i);
            end
        end
        dom        = doy_reg - month_start(midx, leap_reg) + 9'd1;
        day_next   = dom[4:0];
        month_next = midx + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qprod_reg   <= qprod_next;
            d_a_reg     <= d_a_next;
            quad_a_reg  <= quad_a_next;
            d_b_reg     <= d_b_next;
            rem_reg     <= rem_next;
            quad_b_reg  <= quad_b_next;
            year_a_reg  <= year_a_next;
            doy_reg     <= doy_next;
            leap_reg    <= leap_next;
            year_o_reg  <= year_a_reg;
            month_o_reg <= month_next;
            day_o_reg   <= day_next;
        end
    end

    assign day_of_month = day_o_reg;
    assign month_number = month_o_reg;
    assign year_number  = year_o_reg;

endmodule

[sv/epoch_seconds_to_calendar.sv]
// Converts a free-running millisecond count into local calendar time using the
// configured base epoch second, the millisecond count at which it was set and
// a fixed zone offset. Fully pipelined: one transaction may enter every cycle
// while the pipeline is not stalled. The work is a chain of reciprocal
// multiplies (ms to s, s to days, days to 4-year blocks, seconds to minutes
// and hours), each followed by a register. A result not taken stalls the whole
// pipeline; nothing is dropped. Write configuration only while the pipeline is
// empty. Dates cover 1970-01-01 through 2106-02-07.
module epoch_seconds_to_calendar
    import ets_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_number,
    output logic [11:0] year_number
);

    logic [31:0]       base_reg;
    logic [31:0]       set_ms_reg;
    logic [15:0]       zone_reg;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic              adv;
    logic [31:0]       t_sec;
    logic [16:0]       sec_of_day;
    logic [15:0]       day_adj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            set_ms_reg <= '0;
            zone_reg   <= ZONE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index_t'(cfg_index))
                REG_BASE_EPOCH: base_reg   <= cfg_wdata;
                REG_SET_TIME:   set_ms_reg <= cfg_wdata;
                REG_ZONE:       zone_reg   <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    assign adv = !vld_reg[STAGES-1] || out_ready;

    always_comb
    begin
        vld_next = {vld_reg[STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = adv;
    assign out_valid = vld_reg[STAGES-1];

    ets_epoch_sec u_epoch_sec (
        .clk                 (clk),
        .adv                 (adv),
        .now_ms              (now_ms),
        .set_time_ms         (set_ms_reg),
        .base_epoch_seconds  (base_reg),
        .zone_offset_seconds (zone_reg),
        .t_sec               (t_sec)
    );

    ets_day_split u_day_split (
        .clk        (clk),
        .adv        (adv),
        .t_sec      (t_sec),
        .sec_of_day (sec_of_day),
        .day_adj    (day_adj)
    );

    ets_tod u_tod (
        .clk        (clk),
        .adv        (adv),
        .sec_of_day (sec_of_day),
        .second     (second),
        .minute     (minute),
        .hour       (hour)
    );

    ets_date u_date (
        .clk          (clk),
        .adv          (adv),
        .day_adj      (day_adj),
        .day_of_month (day_of_month),
        .month_number (month_number),
        .year_number  (year_number)
    );

endmodule
